FILE: hw/rtl/a2b_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2b_pkg
// Shared types and codes for the length-prefix to start-code converter.
// ----------------------------------------------------------------------------
package a2b_pkg;

    // Extradata parse phases
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LENSZ  = 3'd1,
        PH_SPSCNT = 3'd2,
        PH_PPSCNT = 3'd3,
        PH_SIZE   = 3'd4,
        PH_BODY   = 3'd5,
        PH_DONE   = 3'd6,
        PH_OVER   = 3'd7
    } a2b_phase_t;

    // Result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNC     = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    localparam logic [4:0] NAL_TYPE_IDR  = 5'd5;
    localparam logic [7:0] SC_ZERO       = 8'h00;
    localparam logic [7:0] SC_ONE        = 8'h01;
    localparam logic [2:0] SC_LONG_LEN   = 3'd4;
    localparam logic [2:0] SC_SHORT_LEN  = 3'd3;
    localparam logic [2:0] LEN_FIELD_LEN = 3'd4;

endpackage

FILE: hw/rtl/a2b_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2b_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module a2b_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/avcc_to_annexb_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter_core
// H.264 length-prefixed to start-code stream converter, one byte per transfer.
// ----------------------------------------------------------------------------
// Feed extradata bytes with func=0 and packet bytes with func=1, one byte per
// input transfer, first_byte/last_byte framing each block. Extradata is parsed
// once per block; its SPS and PPS units are kept, each behind a 00 00 00 01
// start code, in a PARAM_BYTES-deep synchronous RAM, and a status result is
// returned on the last extradata byte. In packets each 4-byte length is
// replaced by a start code (four bytes for the first unit, three later) and
// the stored parameter sets are replayed ahead of IDR units. Timing: plain
// packet bytes, length bytes and non-final extradata bytes stream at one per
// cycle while the output is drained. A start code is sent byte by byte from
// S_SC, and the unit's first byte behind it leaves through the tail register;
// a parameter-set replay sends each stored byte through the single registered
// read port, one read in flight, and a size field that completes a unit header
// writes its start-code prefix through the single RAM write port. The input
// stalls while a result of the current transfer cannot yet enter the output
// register.
// There is no clearing pass: the store is only read below the fill count of a
// finished parse.
// ----------------------------------------------------------------------------
module avcc_to_annexb_converter_core #(
    parameter int PARAM_BYTES     = 48,
    parameter int PACKET_LEN_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  in_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [23:0] packet_bytes,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [1:0]  status_code,
    output logic        sps_present,
    output logic        pps_present,
    output logic [2:0]  len_field_size,
    output logic        last_of_run
);

    localparam int AW  = $clog2(PARAM_BYTES);
    localparam int FW  = $clog2(PARAM_BYTES + 1);
    localparam int PLW = (PACKET_LEN_BITS < 24) ? PACKET_LEN_BITS : 24;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PFX,
        S_INS,
        S_SC,
        S_TAIL
    } seq_state_t;

    // sequencer
    seq_state_t       state_reg, state_next;
    logic [AW-1:0]    ins_idx_reg, ins_idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [2:0]       sc_cnt_reg, sc_cnt_next;
    logic [1:0]       pfx_cnt_reg, pfx_cnt_next;
    logic [AW-1:0]    pfx_addr_reg, pfx_addr_next;
    logic             tail_valid_reg, tail_valid_next;
    logic [1:0]       tail_kind_reg, tail_kind_next;
    logic [7:0]       tail_byte_reg, tail_byte_next;
    logic [1:0]       tail_status_reg, tail_status_next;

    // extradata parse state
    a2b_pkg::a2b_phase_t phase_reg, phase_next;
    logic [2:0]       pos_reg, pos_next;
    logic [7:0]       units_reg, units_next;
    logic [15:0]      ubl_reg, ubl_next;
    logic             sps_reg, sps_next;
    logic             pps_reg, pps_next;
    logic             in_pps_reg, in_pps_next;
    logic [2:0]       len_size_reg, len_size_next;
    logic [FW-1:0]    fill_reg, fill_next;

    // packet state
    logic [2:0]       lc_reg, lc_next;
    logic [31:0]      nl_reg, nl_next;
    logic [PLW-1:0]   pl_reg, pl_next;
    logic             first_unit_reg, first_unit_next;
    logic             drop_reg, drop_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       kind_reg, kind_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic [1:0]       status_reg, status_next;
    logic             sps_out_reg, sps_out_next;
    logic             pps_out_reg, pps_out_next;
    logic [2:0]       len_out_reg, len_out_next;
    logic             last_reg, last_next;

    // RAM port
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [7:0]       mem_rdata;

    // per-transfer plan
    logic             in_acc;
    logic             slot_free;
    logic             plan_pfx, plan_ins, plan_sc, plan_tail, direct;
    logic [1:0]       plan_kind;
    logic [7:0]       plan_byte;
    logic [1:0]       plan_status;
    logic             pkt_err;
    logic             ld;
    logic [1:0]       ld_kind;
    logic [7:0]       ld_byte;
    logic [1:0]       ld_status;
    logic             ld_last;

    // extradata values after a possible restart on first_byte
    a2b_pkg::a2b_phase_t ex_phase_c;
    logic [2:0]       ex_pos_c;
    logic [7:0]       ex_units_c, ex_units_dec;
    logic [15:0]      ex_ubl_c, ex_ubl_or, ex_ubl_dec;
    logic             ex_sps_c, ex_pps_c, ex_in_pps_c;
    logic [2:0]       ex_len_c;
    logic [FW-1:0]    ex_fill_c;

    // packet values after a possible restart on first_byte
    logic [PLW-1:0]   pk_pl_c, pk_pl_dec;
    logic [2:0]       pk_lc_c;
    logic [31:0]      pk_nl_c, pk_nl_shift, pk_nl_dec;
    logic             pk_first_c, pk_drop_c;
    logic [FW-1:0]    ins_idx_inc;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    assign ex_phase_c   = first_byte ? a2b_pkg::PH_HEADER : phase_reg;
    assign ex_pos_c     = first_byte ? 3'd0 : pos_reg;
    assign ex_units_c   = first_byte ? 8'd0 : units_reg;
    assign ex_ubl_c     = first_byte ? 16'd0 : ubl_reg;
    assign ex_sps_c     = first_byte ? 1'b0 : sps_reg;
    assign ex_pps_c     = first_byte ? 1'b0 : pps_reg;
    assign ex_in_pps_c  = first_byte ? 1'b0 : in_pps_reg;
    assign ex_len_c     = first_byte ? 3'd1 : len_size_reg;
    assign ex_fill_c    = first_byte ? '0 : fill_reg;
    assign ex_units_dec = ex_units_c - 8'd1;
    assign ex_ubl_or    = ex_ubl_c | {8'h00, in_byte};
    assign ex_ubl_dec   = ex_ubl_c - 16'd1;

    assign pk_pl_c     = first_byte ? packet_bytes[PLW-1:0] : pl_reg;
    assign pk_lc_c     = first_byte ? 3'd0 : lc_reg;
    assign pk_nl_c     = first_byte ? 32'd0 : nl_reg;
    assign pk_first_c  = first_byte ? 1'b1 : first_unit_reg;
    assign pk_drop_c   = first_byte ? 1'b0 : drop_reg;
    assign pk_pl_dec   = pk_pl_c - PLW'(1);
    assign pk_nl_shift = {((pk_lc_c == 3'd0) ? 24'd0 : pk_nl_c[23:0]), in_byte};
    assign pk_nl_dec   = pk_nl_c - 32'd1;

    assign ins_idx_inc = FW'(ins_idx_reg) + FW'(1);

    always_comb
    begin
        state_next       = state_reg;
        ins_idx_next     = ins_idx_reg;
        rd_pend_next     = rd_pend_reg;
        sc_cnt_next      = sc_cnt_reg;
        pfx_cnt_next     = pfx_cnt_reg;
        pfx_addr_next    = pfx_addr_reg;
        tail_valid_next  = tail_valid_reg;
        tail_kind_next   = tail_kind_reg;
        tail_byte_next   = tail_byte_reg;
        tail_status_next = tail_status_reg;

        phase_next      = phase_reg;
        pos_next        = pos_reg;
        units_next      = units_reg;
        ubl_next        = ubl_reg;
        sps_next        = sps_reg;
        pps_next        = pps_reg;
        in_pps_next     = in_pps_reg;
        len_size_next   = len_size_reg;
        fill_next       = fill_reg;

        lc_next         = lc_reg;
        nl_next         = nl_reg;
        pl_next         = pl_reg;
        first_unit_next = first_unit_reg;
        drop_next       = drop_reg;

        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        out_byte_next   = out_byte_reg;
        status_next     = status_reg;
        sps_out_next    = sps_out_reg;
        pps_out_next    = pps_out_reg;
        len_out_next    = len_out_reg;
        last_next       = last_reg;

        mem_we      = 1'b0;
        mem_waddr   = ex_fill_c[AW-1:0];
        mem_wdata   = a2b_pkg::SC_ZERO;
        mem_re      = 1'b0;
        mem_raddr   = ins_idx_reg;

        plan_pfx    = 1'b0;
        plan_ins    = 1'b0;
        plan_sc     = 1'b0;
        plan_tail   = 1'b0;
        plan_kind   = a2b_pkg::KIND_BYTE;
        plan_byte   = in_byte;
        plan_status = a2b_pkg::ST_OK;
        pkt_err     = 1'b0;
        direct      = 1'b0;

        ld        = 1'b0;
        ld_kind   = a2b_pkg::KIND_BYTE;
        ld_byte   = a2b_pkg::SC_ZERO;
        ld_status = a2b_pkg::ST_OK;
        ld_last   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && !func)
                begin
                    // extradata parse step
                    phase_next    = ex_phase_c;
                    pos_next      = ex_pos_c;
                    units_next    = ex_units_c;
                    ubl_next      = ex_ubl_c;
                    sps_next      = ex_sps_c;
                    pps_next      = ex_pps_c;
                    in_pps_next   = ex_in_pps_c;
                    len_size_next = ex_len_c;
                    fill_next     = ex_fill_c;
                    case (ex_phase_c)
                        a2b_pkg::PH_HEADER:
                        begin
                            if (ex_pos_c >= 3'd3)
                            begin
                                pos_next   = 3'd0;
                                phase_next = a2b_pkg::PH_LENSZ;
                            end
                            else
                            begin
                                pos_next = ex_pos_c + 3'd1;
                            end
                        end
                        a2b_pkg::PH_LENSZ:
                        begin
                            len_size_next = {1'b0, in_byte[1:0]} + 3'd1;
                            phase_next    = a2b_pkg::PH_SPSCNT;
                        end
                        a2b_pkg::PH_SPSCNT:
                        begin
                            units_next  = {3'b000, in_byte[4:0]};
                            in_pps_next = 1'b0;
                            pos_next    = 3'd0;
                            if (in_byte[4:0] != 5'd0)
                            begin
                                sps_next   = 1'b1;
                                phase_next = a2b_pkg::PH_SIZE;
                            end
                            else
                            begin
                                phase_next = a2b_pkg::PH_PPSCNT;
                            end
                        end
                        a2b_pkg::PH_PPSCNT:
                        begin
                            units_next  = in_byte;
                            in_pps_next = 1'b1;
                            pos_next    = 3'd0;
                            if (in_byte != 8'd0)
                            begin
                                pps_next   = 1'b1;
                                phase_next = a2b_pkg::PH_SIZE;
                            end
                            else
                            begin
                                phase_next = a2b_pkg::PH_DONE;
                            end
                        end
                        a2b_pkg::PH_SIZE:
                        begin
                            if (ex_pos_c == 3'd0)
                            begin
                                ubl_next = {in_byte, 8'h00};
                                pos_next = 3'd1;
                            end
                            else
                            begin
                                ubl_next = ex_ubl_or;
                                if (ex_fill_c > FW'(PARAM_BYTES - 4))
                                begin
                                    phase_next = a2b_pkg::PH_OVER;
                                end
                                else
                                begin
                                    // first prefix byte now, three more in S_PFX
                                    plan_pfx  = 1'b1;
                                    mem_we    = 1'b1;
                                    mem_wdata = a2b_pkg::SC_ZERO;
                                    fill_next = ex_fill_c + FW'(4);
                                    if (ex_ubl_or == 16'd0)
                                    begin
                                        units_next = ex_units_dec;
                                        pos_next   = 3'd0;
                                        if (ex_units_dec != 8'd0)
                                            phase_next = a2b_pkg::PH_SIZE;
                                        else if (ex_in_pps_c)
                                            phase_next = a2b_pkg::PH_DONE;
                                        else
                                            phase_next = a2b_pkg::PH_PPSCNT;
                                    end
                                    else
                                    begin
                                        phase_next = a2b_pkg::PH_BODY;
                                    end
                                end
                            end
                        end
                        a2b_pkg::PH_BODY:
                        begin
                            if (ex_fill_c >= FW'(PARAM_BYTES))
                            begin
                                phase_next = a2b_pkg::PH_OVER;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = in_byte;
                                fill_next = ex_fill_c + FW'(1);
                                ubl_next  = ex_ubl_dec;
                                if (ex_ubl_dec == 16'd0)
                                begin
                                    units_next = ex_units_dec;
                                    pos_next   = 3'd0;
                                    if (ex_units_dec != 8'd0)
                                        phase_next = a2b_pkg::PH_SIZE;
                                    else if (ex_in_pps_c)
                                        phase_next = a2b_pkg::PH_DONE;
                                    else
                                        phase_next = a2b_pkg::PH_PPSCNT;
                                end
                            end
                        end
                        default:
                        begin
                            // finished or overflowed: byte ignored
                        end
                    endcase
                    if (last_byte)
                    begin
                        plan_tail = 1'b1;
                        plan_kind = a2b_pkg::KIND_STATUS;
                        plan_byte = 8'h00;
                        if (phase_next == a2b_pkg::PH_DONE)
                            plan_status = a2b_pkg::ST_OK;
                        else if (phase_next == a2b_pkg::PH_OVER)
                            plan_status = a2b_pkg::ST_OVERFLOW;
                        else
                            plan_status = a2b_pkg::ST_TRUNC;
                    end
                end
                else if (in_acc)
                begin
                    // packet step
                    pl_next         = pk_pl_c;
                    lc_next         = pk_lc_c;
                    nl_next         = pk_nl_c;
                    first_unit_next = pk_first_c;
                    drop_next       = pk_drop_c;
                    if (!pk_drop_c)
                    begin
                        if (pk_pl_c == '0)
                        begin
                            pkt_err = 1'b1;
                        end
                        else
                        begin
                            pl_next = pk_pl_dec;
                            if (pk_lc_c < a2b_pkg::LEN_FIELD_LEN)
                            begin
                                nl_next = pk_nl_shift;
                                lc_next = pk_lc_c + 3'd1;
                                if (pk_lc_c == 3'd3)
                                begin
                                    if (pk_nl_shift > 32'(pk_pl_dec))
                                    begin
                                        pkt_err = 1'b1;
                                    end
                                    else if (pk_nl_shift == 32'd0)
                                    begin
                                        // zero-length unit: start code only
                                        plan_sc = 1'b1;
                                        lc_next = 3'd0;
                                    end
                                end
                            end
                            else
                            begin
                                if (pk_lc_c == a2b_pkg::LEN_FIELD_LEN)
                                begin
                                    plan_sc  = 1'b1;
                                    plan_ins = (in_byte[4:0] == a2b_pkg::NAL_TYPE_IDR) &&
                                               (phase_reg == a2b_pkg::PH_DONE) &&
                                               (fill_reg != '0);
                                end
                                plan_tail = 1'b1;
                                plan_kind = a2b_pkg::KIND_BYTE;
                                plan_byte = in_byte;
                                nl_next   = pk_nl_dec;
                                lc_next   = (pk_nl_dec != 32'd0) ? 3'd5 : 3'd0;
                            end
                            if ((pk_pl_dec == '0 && lc_next != 3'd0) ||
                                (last_byte && (pk_pl_dec != '0 || lc_next != 3'd0)))
                            begin
                                pkt_err = 1'b1;
                            end
                        end
                        if (pkt_err)
                        begin
                            // one error result replaces everything else
                            drop_next   = 1'b1;
                            plan_sc     = 1'b0;
                            plan_ins    = 1'b0;
                            plan_tail   = 1'b1;
                            plan_kind   = a2b_pkg::KIND_ERROR;
                            plan_byte   = 8'h00;
                            plan_status = a2b_pkg::ST_MALFORMED;
                        end
                        else if (plan_sc)
                        begin
                            first_unit_next = 1'b0;
                        end
                    end
                end

                if (in_acc)
                begin
                    direct = plan_tail && !plan_ins && !plan_sc && slot_free;
                    if (direct)
                    begin
                        ld        = 1'b1;
                        ld_kind   = plan_kind;
                        ld_byte   = plan_byte;
                        ld_status = plan_status;
                        ld_last   = 1'b1;
                    end
                    tail_valid_next  = plan_tail && !direct;
                    tail_kind_next   = plan_kind;
                    tail_byte_next   = plan_byte;
                    tail_status_next = plan_status;
                    sc_cnt_next      = pk_first_c ? a2b_pkg::SC_LONG_LEN
                                                  : a2b_pkg::SC_SHORT_LEN;
                    ins_idx_next     = '0;
                    rd_pend_next     = 1'b0;
                    pfx_cnt_next     = 2'd0;
                    pfx_addr_next    = ex_fill_c[AW-1:0] + AW'(1);
                    if (plan_pfx)
                        state_next = S_PFX;
                    else if (plan_ins)
                        state_next = S_INS;
                    else if (plan_sc)
                        state_next = S_SC;
                    else if (plan_tail && !direct)
                        state_next = S_TAIL;
                    else
                        state_next = S_IDLE;
                end
            end

            S_PFX:
            begin
                // remaining prefix bytes 00 00 01
                mem_we        = 1'b1;
                mem_waddr     = pfx_addr_reg;
                mem_wdata     = (pfx_cnt_reg == 2'd2) ? a2b_pkg::SC_ONE : a2b_pkg::SC_ZERO;
                pfx_addr_next = pfx_addr_reg + AW'(1);
                pfx_cnt_next  = pfx_cnt_reg + 2'd1;
                if (pfx_cnt_reg == 2'd2)
                    state_next = tail_valid_reg ? S_TAIL : S_IDLE;
            end

            S_INS:
            begin
                // stream stored parameter sets, one read in flight
                if (!rd_pend_reg)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = ins_idx_reg;
                    rd_pend_next = 1'b1;
                end
                else if (slot_free)
                begin
                    ld      = 1'b1;
                    ld_kind = a2b_pkg::KIND_BYTE;
                    ld_byte = mem_rdata;
                    ld_last = 1'b0;
                    if (ins_idx_inc == fill_reg)
                    begin
                        rd_pend_next = 1'b0;
                        state_next   = S_SC;
                    end
                    else
                    begin
                        ins_idx_next = ins_idx_inc[AW-1:0];
                        mem_re       = 1'b1;
                        mem_raddr    = ins_idx_inc[AW-1:0];
                    end
                end
            end

            S_SC:
            begin
                if (slot_free)
                begin
                    ld          = 1'b1;
                    ld_kind     = a2b_pkg::KIND_BYTE;
                    ld_byte     = (sc_cnt_reg == 3'd1) ? a2b_pkg::SC_ONE : a2b_pkg::SC_ZERO;
                    ld_last     = (sc_cnt_reg == 3'd1) && !tail_valid_reg;
                    sc_cnt_next = sc_cnt_reg - 3'd1;
                    if (sc_cnt_reg == 3'd1)
                        state_next = tail_valid_reg ? S_TAIL : S_IDLE;
                end
            end

            S_TAIL:
            begin
                if (slot_free)
                begin
                    ld              = 1'b1;
                    ld_kind         = tail_kind_reg;
                    ld_byte         = tail_byte_reg;
                    ld_status       = tail_status_reg;
                    ld_last         = 1'b1;
                    tail_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ld)
        begin
            out_valid_next = 1'b1;
            kind_next      = ld_kind;
            out_byte_next  = ld_byte;
            status_next    = ld_status;
            sps_out_next   = sps_next;
            pps_out_next   = pps_next;
            len_out_next   = len_size_next;
            last_next      = ld_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ins_idx_reg     <= '0;
            rd_pend_reg     <= 1'b0;
            sc_cnt_reg      <= 3'd0;
            pfx_cnt_reg     <= 2'd0;
            pfx_addr_reg    <= '0;
            tail_valid_reg  <= 1'b0;
            tail_kind_reg   <= a2b_pkg::KIND_BYTE;
            tail_byte_reg   <= 8'h00;
            tail_status_reg <= a2b_pkg::ST_OK;
            phase_reg       <= a2b_pkg::PH_HEADER;
            pos_reg         <= 3'd0;
            units_reg       <= 8'd0;
            ubl_reg         <= 16'd0;
            sps_reg         <= 1'b0;
            pps_reg         <= 1'b0;
            in_pps_reg      <= 1'b0;
            len_size_reg    <= 3'd1;
            fill_reg        <= '0;
            lc_reg          <= 3'd0;
            nl_reg          <= 32'd0;
            pl_reg          <= '0;
            first_unit_reg  <= 1'b1;
            drop_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            kind_reg        <= a2b_pkg::KIND_BYTE;
            out_byte_reg    <= 8'h00;
            status_reg      <= a2b_pkg::ST_OK;
            sps_out_reg     <= 1'b0;
            pps_out_reg     <= 1'b0;
            len_out_reg     <= 3'd1;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ins_idx_reg     <= ins_idx_next;
            rd_pend_reg     <= rd_pend_next;
            sc_cnt_reg      <= sc_cnt_next;
            pfx_cnt_reg     <= pfx_cnt_next;
            pfx_addr_reg    <= pfx_addr_next;
            tail_valid_reg  <= tail_valid_next;
            tail_kind_reg   <= tail_kind_next;
            tail_byte_reg   <= tail_byte_next;
            tail_status_reg <= tail_status_next;
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            units_reg       <= units_next;
            ubl_reg         <= ubl_next;
            sps_reg         <= sps_next;
            pps_reg         <= pps_next;
            in_pps_reg      <= in_pps_next;
            len_size_reg    <= len_size_next;
            fill_reg        <= fill_next;
            lc_reg          <= lc_next;
            nl_reg          <= nl_next;
            pl_reg          <= pl_next;
            first_unit_reg  <= first_unit_next;
            drop_reg        <= drop_next;
            out_valid_reg   <= out_valid_next;
            kind_reg        <= kind_next;
            out_byte_reg    <= out_byte_next;
            status_reg      <= status_next;
            sps_out_reg     <= sps_out_next;
            pps_out_reg     <= pps_out_next;
            len_out_reg     <= len_out_next;
            last_reg        <= last_next;
        end
    end

    // parameter-set store
    a2b_ram #(
        .WIDTH (8),
        .DEPTH (PARAM_BYTES)
    ) u_param_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign out_byte       = out_byte_reg;
    assign status_code    = status_reg;
    assign sps_present    = sps_out_reg;
    assign pps_present    = pps_out_reg;
    assign len_field_size = len_out_reg;
    assign last_of_run    = last_reg;

    // store is never written while it is being replayed
    a_no_write_during_replay: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |-> !mem_we)
        else $error("param store written during replay");

    // replay index stays inside the filled part of the store
    a_replay_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |-> (FW'(ins_idx_reg) < fill_reg))
        else $error("replay index beyond fill");

    // a malformed packet byte sets the drop flag
    a_err_sets_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && func && pkt_err) |=> drop_reg)
        else $error("packet error did not set drop");

    // start-code state always has bytes left to send
    a_sc_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SC) |-> (sc_cnt_reg != 3'd0))
        else $error("start-code count empty");

endmodule
